>>> rtl/core/bounded_ring_fifo_with_watermark_top_defines.svh
// Assertion macros for the bounded ring FIFO with watermark.
`ifndef BOUNDED_RING_FIFO_WITH_WATERMARK_TOP_DEFINES_SVH
`define BOUNDED_RING_FIFO_WITH_WATERMARK_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define BRFW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BRFW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BRFW_ASSERT(lbl, clk, rst_n, prop, msg)
`define BRFW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/core/brfw_pkg.sv
// Constants and types of the bounded ring FIFO with watermark.
`default_nettype none

package brfw_pkg;

    localparam int DEPTH_LOG2 = 6;
    localparam int MAX_BURST  = 4;
    localparam int DATA_WIDTH = 64;

    localparam int SLOTS  = 1 << DEPTH_LOG2;
    localparam int CNT_W  = DEPTH_LOG2 + 1;
    localparam int N_W    = $clog2(MAX_BURST + 1);
    localparam int SEL_W  = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;
    localparam int SUM_W  = (CNT_W + N_W + 1 > 8) ? CNT_W + N_W + 1 : 8;

    localparam int SIZE_W = 3;
    localparam int WM_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int COUNT_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WATERMARK = 2'd1;

    localparam logic [SIZE_W-1:0] SIZE_LOG2_RST = 3'd6;
    localparam logic [WM_W-1:0]   WATERMARK_RST = 7'd64;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_OVER   = 2'd1,
        ST_NOROOM = 2'd2,
        ST_NOENT  = 2'd3
    } t_status;

    typedef logic [DATA_WIDTH-1:0] t_word;

endpackage

`default_nettype wire

>>> rtl/core/bounded_ring_fifo_with_watermark_top.sv
// Bounded ring FIFO with watermark: control, entry memory and result register.
//
// Input channel (i_in_valid / o_in_stall) carries one burst item: i_kind selects
// enqueue or dequeue, i_count the number of words (saturated to four), and
// i_word_0..3 the words to store. Results leave on o_out_valid / i_out_stall,
// one registered item per cycle at most.
// An enqueue writes its words to the single-port entry memory one per cycle and
// then issues one status item, loaded into the output register once it is free.
// A dequeue reads one word per cycle from the memory while the output does not
// stall, registers each read word and issues one item per word, the last one
// flagged. Failed or empty bursts give a single status item and touch no
// memory word.
// One burst is handled at a time; the next is taken once the previous has
// handed its last item to the output register.
// A stall on the output holds the result register and the memory read data;
// work resumes when the stall drops, nothing is lost.
// Configuration (i_cfg_valid / o_cfg_ready, index 0 size_log2, 1 watermark) is
// taken while no burst is in progress.
// Reset clears both ring counters and restores size_log2 = 6, watermark = 64;
// the entry memory is not cleared and needs no clearing pass.
`default_nettype none

`include "bounded_ring_fifo_with_watermark_top_defines.svh"

module bounded_ring_fifo_with_watermark_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_kind,
    input  wire logic [brfw_pkg::COUNT_W-1:0]    i_count,
    input  wire logic [brfw_pkg::DATA_WIDTH-1:0] i_word_0,
    input  wire logic [brfw_pkg::DATA_WIDTH-1:0] i_word_1,
    input  wire logic [brfw_pkg::DATA_WIDTH-1:0] i_word_2,
    input  wire logic [brfw_pkg::DATA_WIDTH-1:0] i_word_3,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [1:0]                           o_status,
    output logic [brfw_pkg::DATA_WIDTH-1:0]      o_data,
    output logic                                 o_last,
    output logic                                 o_full_res,
    output logic                                 o_empty_res,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [brfw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [brfw_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WRITE = 4'b0010,
        S_READ  = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    localparam int DL = brfw_pkg::DEPTH_LOG2;
    localparam int CW = brfw_pkg::CNT_W;
    localparam int NW = brfw_pkg::N_W;
    localparam int SW = brfw_pkg::SUM_W;

    t_state                         r_state, n_state;
    logic [CW-1:0]                  r_prod, n_prod;
    logic [CW-1:0]                  r_cons, n_cons;
    logic [brfw_pkg::SIZE_W-1:0]    r_size_log2;
    logic [brfw_pkg::WM_W-1:0]      r_watermark;
    logic [NW-1:0]                  r_rem, n_rem;
    logic [NW-1:0]                  r_idx, n_idx;
    logic                           r_q_valid, n_q_valid;
    logic                           r_q_last;
    logic                           r_out_valid, n_out_valid;

    logic [DL-1:0]                  r_addr;
    logic [DL-1:0]                  r_mask;
    brfw_pkg::t_word                r_words [brfw_pkg::MAX_BURST];
    brfw_pkg::t_status              r_res_status;
    logic                           r_res_full;
    logic                           r_res_empty;
    brfw_pkg::t_word                r_mem [brfw_pkg::SLOTS];
    brfw_pkg::t_word                r_mem_q;

    brfw_pkg::t_status              r_o_status;
    brfw_pkg::t_word                r_o_data;
    logic                           r_o_last;
    logic                           r_o_full;
    logic                           r_o_empty;

    brfw_pkg::t_word                w_in [brfw_pkg::MAX_BURST];
    logic                           acc;
    logic                           out_free;
    logic                           mem_we;
    logic                           rd_go;
    logic                           emit_load;
    logic                           rd_load;
    logic [brfw_pkg::SIZE_W-1:0]    lg;
    logic [DL-1:0]                  mask;
    logic [CW-1:0]                  used;
    logic [CW-1:0]                  free_room;
    logic [NW-1:0]                  n_sat;
    logic [SW-1:0]                  n_ext;
    logic                           enq_fail;
    logic                           deq_fail;
    logic                           op_ok;
    logic [CW-1:0]                  post_used;
    brfw_pkg::t_status              dec_status;

    assign w_in[0] = i_word_0;
    assign w_in[1] = i_word_1;
    assign w_in[2] = i_word_2;
    assign w_in[3] = i_word_3;

    assign acc         = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        if (r_size_log2 == '0) begin
            lg = brfw_pkg::SIZE_W'(1);
        end else if (r_size_log2 > brfw_pkg::SIZE_W'(DL)) begin
            lg = brfw_pkg::SIZE_W'(DL);
        end else begin
            lg = r_size_log2;
        end
        for (int b = 0; b < DL; b++) begin
            mask[b] = (b < int'(lg));
        end
    end

    assign used      = r_prod - r_cons;
    assign free_room = (used >= CW'(mask)) ? '0 : CW'(mask) - used;
    assign n_sat     = (i_count > brfw_pkg::COUNT_W'(brfw_pkg::MAX_BURST)) ?
                       NW'(brfw_pkg::MAX_BURST) : NW'(i_count);
    assign n_ext     = SW'(n_sat);
    assign enq_fail  = n_ext > SW'(free_room);
    assign deq_fail  = n_ext > SW'(used);
    assign op_ok     = (i_kind == brfw_pkg::KIND_ENQ) ? !enq_fail : !deq_fail;

    always_comb begin
        post_used = used;
        if (op_ok) begin
            if (i_kind == brfw_pkg::KIND_ENQ) begin
                post_used = used + CW'(n_sat);
            end else begin
                post_used = used - CW'(n_sat);
            end
        end
    end

    always_comb begin
        if (i_kind == brfw_pkg::KIND_ENQ) begin
            if (enq_fail) begin
                dec_status = brfw_pkg::ST_NOROOM;
            end else if (SW'(used) + n_ext + SW'(1) > SW'(r_watermark)) begin
                dec_status = brfw_pkg::ST_OVER;
            end else begin
                dec_status = brfw_pkg::ST_OK;
            end
        end else begin
            dec_status = deq_fail ? brfw_pkg::ST_NOENT : brfw_pkg::ST_OK;
        end
    end

    assign mem_we    = (r_state == S_WRITE);
    assign rd_go     = (r_state == S_READ) && (r_rem != '0) && (!r_q_valid || out_free);
    assign rd_load   = (r_state == S_READ) && r_q_valid && out_free;
    assign emit_load = (r_state == S_EMIT) && out_free;

    always_comb begin
        n_state     = r_state;
        n_prod      = r_prod;
        n_cons      = r_cons;
        n_rem       = r_rem;
        n_idx       = r_idx;
        n_q_valid   = r_q_valid;
        n_out_valid = r_out_valid;
        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (rd_load || emit_load) begin
            n_out_valid = 1'b1;
        end
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_idx = '0;
                    n_rem = op_ok ? n_sat : '0;
                    if (!op_ok || n_sat == '0) begin
                        n_state = S_EMIT;
                    end else if (i_kind == brfw_pkg::KIND_ENQ) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_READ;
                    end
                    if (op_ok && i_kind == brfw_pkg::KIND_ENQ) begin
                        n_prod = r_prod + CW'(n_sat);
                    end
                    if (op_ok && i_kind == brfw_pkg::KIND_DEQ) begin
                        n_cons = r_cons + CW'(n_sat);
                    end
                end
            end
            S_WRITE: begin
                n_idx = r_idx + NW'(1);
                n_rem = r_rem - NW'(1);
                if (r_rem == NW'(1)) begin
                    n_state = S_EMIT;
                end
            end
            S_READ: begin
                if (rd_go) begin
                    n_rem     = r_rem - NW'(1);
                    n_q_valid = 1'b1;
                end else if (rd_load) begin
                    n_q_valid = 1'b0;
                end
                if (rd_load && r_rem == '0) begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (emit_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prod      <= '0;
            r_cons      <= '0;
            r_rem       <= '0;
            r_idx       <= '0;
            r_q_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_size_log2 <= brfw_pkg::SIZE_LOG2_RST;
            r_watermark <= brfw_pkg::WATERMARK_RST;
        end else begin
            r_state     <= n_state;
            r_prod      <= n_prod;
            r_cons      <= n_cons;
            r_rem       <= n_rem;
            r_idx       <= n_idx;
            r_q_valid   <= n_q_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == brfw_pkg::CFG_SIZE_LOG2) begin
                    r_size_log2 <= i_cfg_data[brfw_pkg::SIZE_W-1:0];
                end else if (i_cfg_index == brfw_pkg::CFG_WATERMARK) begin
                    r_watermark <= i_cfg_data[brfw_pkg::WM_W-1:0];
                end
            end
        end
    end

    // burst context, latched at accept
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_words      <= w_in;
            r_mask       <= mask;
            r_res_status <= dec_status;
            r_res_full   <= (post_used >= CW'(mask));
            r_res_empty  <= (post_used == '0);
            if (i_kind == brfw_pkg::KIND_ENQ) begin
                r_addr <= r_prod[DL-1:0] & mask;
            end else begin
                r_addr <= r_cons[DL-1:0] & mask;
            end
        end else if (mem_we || rd_go) begin
            r_addr <= (r_addr + DL'(1)) & r_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= r_words[r_idx[brfw_pkg::SEL_W-1:0]];
        end
        if (rd_go) begin
            r_mem_q  <= r_mem[r_addr];
            r_q_last <= (r_rem == NW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_load) begin
            r_o_status <= brfw_pkg::ST_OK;
            r_o_data   <= r_mem_q;
            r_o_last   <= r_q_last;
            r_o_full   <= r_res_full;
            r_o_empty  <= r_res_empty;
        end else if (emit_load) begin
            r_o_status <= r_res_status;
            r_o_data   <= '0;
            r_o_last   <= 1'b1;
            r_o_full   <= r_res_full;
            r_o_empty  <= r_res_empty;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_o_status;
    assign o_data      = r_o_data;
    assign o_last      = r_o_last;
    assign o_full_res  = r_o_full;
    assign o_empty_res = r_o_empty;

    `BRFW_ASSERT(a_single_port, i_clk, i_rst_n, !(mem_we && rd_go), "memory port used twice")
    `BRFW_ASSERT(a_idle_clean, i_clk, i_rst_n, (r_state == S_IDLE) |-> (!r_q_valid && r_rem == '0), "burst left work behind")
    `BRFW_ASSERT(a_prod_step, i_clk, i_rst_n, (acc && i_kind == brfw_pkg::KIND_ENQ && !enq_fail) |=> (r_prod == $past(r_prod) + CW'($past(n_sat))), "producer counter step wrong")
    `BRFW_ASSERT(a_load_free, i_clk, i_rst_n, (rd_load || emit_load) |-> out_free, "result register overwritten")

endmodule

`default_nettype wire
